[rtl/mtg_pkg.sv]
// Shared types and constants for the MT19937 generator.
// Used by the generator modules and the testbench; depends on nothing.
package mtg_pkg;

  localparam int WORD_W = 32;

  // Request codes on the func field.
  localparam logic [1:0] FUNC_DRAW = 2'd0;
  localparam logic [1:0] FUNC_SEED = 2'd1;
  localparam logic [1:0] FUNC_LOAD = 2'd2;

  // Recurrence offset of the twist.
  localparam int SHIFT_OFFSET = 397;

  localparam logic [WORD_W-1:0] TWIST_XOR      = 32'h9908b0df;
  localparam logic [WORD_W-1:0] MSB_MASK       = 32'h80000000;
  localparam logic [WORD_W-1:0] LOW31_MASK     = 32'h7fffffff;
  localparam logic [WORD_W-1:0] TEMPER_B       = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C       = 32'hefc60000;
  localparam logic [WORD_W-1:0] HIGH_HALF_MASK = 32'hffff0000;

  // Seeding recurrence s = s * 69069 + 1. Two steps at once use the squared
  // multiplier (modulo 2^32) and the combined increment 69069 + 1.
  localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
  localparam logic [WORD_W-1:0] LCG_MULT2    = 32'd475559465;
  localparam logic [WORD_W-1:0] LCG_INC2     = 32'd69070;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

  typedef struct packed {
    logic load;
    logic step;
  } lcg_ctrl_t;

endpackage

[rtl/mtg_cell.sv]
// One cell of the state chain: holds a single 32-bit state word.
// Depends on mtg_pkg for the word width.
module mtg_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [mtg_pkg::WORD_W-1:0] d,
  output logic [mtg_pkg::WORD_W-1:0] q
);

  // On every shift the cell takes the word on its d input.
  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

[rtl/mtg_lcg.sv]
// Seed expansion unit: produces one state word per step from the
// 69069 linear congruential recurrence. Depends on mtg_pkg.
module mtg_lcg (
  input  logic                       clk,
  input  mtg_pkg::lcg_ctrl_t         ctrl,
  input  logic [mtg_pkg::WORD_W-1:0] seed,
  output logic [mtg_pkg::WORD_W-1:0] word
);

  logic [mtg_pkg::WORD_W-1:0] s;
  logic [mtg_pkg::WORD_W-1:0] s_odd;
  logic [mtg_pkg::WORD_W-1:0] s_next;

  // The high half of the current value and of the following one form a word.
  assign s_odd  = mtg_pkg::WORD_W'(s * mtg_pkg::LCG_MULT) + 32'd1;
  assign s_next = mtg_pkg::WORD_W'(s * mtg_pkg::LCG_MULT2) + mtg_pkg::LCG_INC2;
  assign word   = (s & mtg_pkg::HIGH_HALF_MASK) |
                  ((s_odd & mtg_pkg::HIGH_HALF_MASK) >> 16);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s <= seed;
    end else if (ctrl.step) begin
      s <= s_next;
    end
  end

endmodule

[rtl/mersenne_twister_generator_top.sv]
// MT19937 generator: the 624-word state sits in a ring of cells that shifts
// toward cell 0, with taps at cells 0, 1 and 397. A draw that is due a twist
// twists the word at the head of the ring as it is read, so a stream of draws
// delivers one word per cycle while the output is not stalled, including across
// the point where the original scheme twists the whole state. A seed fills the
// state one word per cycle from the linear congruential unit; the first draw
// after reset seeds with 4357 before it presents its word. Loads in order after
// a seed find their word at the head of the ring. A load or draw that does not
// find its word at the head of the ring first rotates the ring one word per
// cycle, and a load that arrives in the middle of a stream of draws first
// finishes the pending twist. An input word is taken only while the output
// register is free or being emptied in the same cycle.
module mersenne_twister_generator_top #(
  parameter int STATE_DEPTH = 624
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  func,
  input  logic [31:0] seed_value,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] random_word
);

  localparam int IDX_W = $clog2(STATE_DEPTH);
  localparam int POS_W = $clog2(STATE_DEPTH + 2);
  localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(STATE_DEPTH - 1);
  localparam logic [POS_W-1:0] TWIST_DUE    = POS_W'(STATE_DEPTH);
  localparam logic [POS_W-1:0] NEVER_SEEDED = POS_W'(STATE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEED,
    S_FINISH,
    S_ALIGN
  } state_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_ROTATE,
    ACT_TWIST,
    ACT_FILL,
    ACT_LOAD
  } act_t;

  function automatic logic [31:0] mix_fn(input logic [31:0] hi, input logic [31:0] lo,
                                         input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] r;
    y = (hi & mtg_pkg::MSB_MASK) | (lo & mtg_pkg::LOW31_MASK);
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ mtg_pkg::TWIST_XOR;
    end
    return r;
  endfunction

  function automatic logic [31:0] temper_fn(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  state_t     state, state_next;
  logic [IDX_W-1:0] rot, rot_next, rot_inc;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] lpos, lpos_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             lazy, lazy_next;
  logic [1:0]       pend_func, pend_func_next;
  logic [31:0]      pend_val, pend_val_next;
  logic             rsp_valid_next;
  logic [31:0]      random_word_next;

  act_t               act;
  logic               shift_en;
  logic [31:0]        tail;
  logic [31:0]        load_word;
  logic [31:0]        mix_word;
  logic [31:0]        draw_word;
  logic [POS_W-1:0]   draw_target;
  logic               draw_ok;
  logic               load_ok;
  logic               do_draw;
  logic               do_load;
  logic               accept;
  mtg_pkg::lcg_ctrl_t lcg_ctrl;
  logic [31:0]        lcg_seed;
  logic [31:0]        lcg_word;

  logic [31:0] q [STATE_DEPTH];

  // ---------------------------------------------------------------------------
  // State ring.
  genvar gi;
  generate
    for (gi = 0; gi < STATE_DEPTH; gi++) begin : g_cell
      if (gi == STATE_DEPTH - 1) begin : g_tail
        mtg_cell u_cell (.clk(clk), .en(shift_en), .d(tail), .q(q[gi]));
      end else begin : g_body
        mtg_cell u_cell (.clk(clk), .en(shift_en), .d(q[gi+1]), .q(q[gi]));
      end
    end
  endgenerate

  mtg_lcg u_lcg (
    .clk (clk),
    .ctrl(lcg_ctrl),
    .seed(lcg_seed),
    .word(lcg_word)
  );

  assign mix_word = mix_fn(q[0], q[1], q[mtg_pkg::SHIFT_OFFSET]);
  assign shift_en = (act != ACT_HOLD);

  always_comb begin
    case (act)
      ACT_TWIST: tail = mix_word;
      ACT_FILL:  tail = lcg_word;
      ACT_LOAD:  tail = load_word;
      default:   tail = q[0];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control.
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign rot_inc   = (rot == LAST_IDX) ? '0 : rot + IDX_W'(1);

  // While a twist is in flight (lazy) the head is always the word to draw.
  assign draw_target = (pos == TWIST_DUE) ? '0 : pos;
  assign draw_ok     = (pos != NEVER_SEEDED) && (lazy || (POS_W'(rot) == draw_target));
  assign load_ok     = !lazy && (POS_W'(rot) == lpos);
  assign draw_word   = (lazy || (pos == TWIST_DUE)) ? temper_fn(mix_word) : temper_fn(q[0]);
  assign load_word   = (state == S_IDLE) ? seed_value : pend_val;

  always_comb begin
    state_next       = state;
    rot_next         = rot;
    pos_next         = pos;
    lpos_next        = lpos;
    cnt_next         = cnt;
    lazy_next        = lazy;
    pend_func_next   = pend_func;
    pend_val_next    = pend_val;
    act              = ACT_HOLD;
    lcg_ctrl         = '0;
    lcg_seed         = seed_value;
    do_draw          = 1'b0;
    do_load          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pend_func_next = func;
          pend_val_next  = seed_value;
          unique case (func)
            mtg_pkg::FUNC_DRAW: begin
              if (draw_ok) begin
                do_draw = 1'b1;
              end else if (pos == NEVER_SEEDED) begin
                lcg_seed      = mtg_pkg::DEFAULT_SEED;
                lcg_ctrl.load = 1'b1;
                cnt_next      = '0;
                state_next    = S_SEED;
              end else begin
                state_next = S_ALIGN;
              end
            end
            mtg_pkg::FUNC_SEED: begin
              lcg_ctrl.load = 1'b1;
              lazy_next     = 1'b0;
              cnt_next      = '0;
              state_next    = S_SEED;
            end
            mtg_pkg::FUNC_LOAD: begin
              if (lpos < TWIST_DUE) begin
                if (load_ok) begin
                  do_load = 1'b1;
                end else if (lazy) begin
                  lazy_next  = 1'b0;
                  state_next = S_FINISH;
                end else begin
                  state_next = S_ALIGN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEED: begin
        act           = ACT_FILL;
        lcg_ctrl.step = 1'b1;
        cnt_next      = cnt + IDX_W'(1);
        if (cnt == LAST_IDX) begin
          rot_next   = '0;
          pos_next   = TWIST_DUE;
          lpos_next  = '0;
          state_next = (pend_func == mtg_pkg::FUNC_DRAW) ? S_ALIGN : S_IDLE;
        end
      end
      S_FINISH: begin
        // Complete the twist that a stream of draws left half done.
        act      = ACT_TWIST;
        rot_next = rot_inc;
        if (rot == LAST_IDX) begin
          state_next = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (pend_func == mtg_pkg::FUNC_DRAW && draw_ok) begin
          do_draw    = 1'b1;
          state_next = S_IDLE;
        end else if (pend_func == mtg_pkg::FUNC_LOAD && load_ok) begin
          do_load    = 1'b1;
          state_next = S_IDLE;
        end else begin
          act      = ACT_ROTATE;
          rot_next = rot_inc;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_draw) begin
      rot_next = rot_inc;
      if (lazy || (pos == TWIST_DUE)) begin
        act       = ACT_TWIST;
        lazy_next = (rot != LAST_IDX);
        pos_next  = (rot == LAST_IDX) ? TWIST_DUE : POS_W'(rot_inc);
      end else begin
        act      = ACT_ROTATE;
        pos_next = pos + POS_W'(1);
      end
    end

    if (do_load) begin
      act       = ACT_LOAD;
      rot_next  = rot_inc;
      lpos_next = lpos + POS_W'(1);
      if (lpos == POS_W'(LAST_IDX)) begin
        pos_next = TWIST_DUE;
      end
    end

    rsp_valid_next   = do_draw || (rsp_valid && !rsp_ready);
    random_word_next = do_draw ? draw_word : random_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rot       <= '0;
      pos       <= NEVER_SEEDED;
      lpos      <= '0;
      cnt       <= '0;
      lazy      <= 1'b0;
      pend_func <= mtg_pkg::FUNC_DRAW;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rot       <= rot_next;
      pos       <= pos_next;
      lpos      <= lpos_next;
      cnt       <= cnt_next;
      lazy      <= lazy_next;
      pend_func <= pend_func_next;
      rsp_valid <= rsp_valid_next;
    end
    pend_val    <= pend_val_next;
    random_word <= random_word_next;
  end

`ifndef ASSERT_OFF
  // A twist in flight keeps the read position at the head of the ring.
  a_lazy_aligned: assert property (@(posedge clk) disable iff (rst)
    lazy |-> (pos == POS_W'(rot)))
    else $error("twist in flight but read position is off the ring head");

  // Multi-cycle work only starts with the output register empty.
  a_busy_no_word: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !rsp_valid)
    else $error("output word pending while a request is in progress");

  // Only a load interrupts a twist in flight.
  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> (pend_func == mtg_pkg::FUNC_LOAD))
    else $error("twist completion started for a request other than a load");

  a_counters_range: assert property (@(posedge clk) disable iff (rst)
    (rot <= LAST_IDX) && (pos <= NEVER_SEEDED) && (lpos <= TWIST_DUE))
    else $error("position counter out of range");

  // The last fill cycle leaves an aligned ring with a twist due.
  a_seed_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEED && cnt == LAST_IDX) |=>
      (rot == '0 && pos == TWIST_DUE && lpos == '0 && !lazy))
    else $error("seed fill ended with wrong positions");
`endif

endmodule

[tb/sv/mersenne_twister_generator_checker.sv]
`timescale 1ns / 100ps
// Checker for the MT19937 generator: it watches both channels, predicts every drawn word
// and compares it with the word the block returns. Depends on mtg_pkg.
module mersenne_twister_generator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [1:0]  func,
  input  logic [31:0] seed_value,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [31:0] random_word,
  output int          fail_count,
  output int          words_waiting
);

  localparam int DEPTH    = 624;
  localparam int UNSEEDED = DEPTH + 1;

  logic [31:0] mt_words [DEPTH];
  int          read_pos;
  int          fill_pos;
  logic [31:0] expected_words [$];
  int          errors = 0;

  function automatic void seed_state(input logic [31:0] seed);
    logic [31:0] acc;
    logic [31:0] w;
    acc = seed;
    for (int i = 0; i < DEPTH; i++) begin
      w   = acc & mtg_pkg::HIGH_HALF_MASK;
      acc = acc * mtg_pkg::LCG_MULT + 32'd1;
      w   = w | ((acc & mtg_pkg::HIGH_HALF_MASK) >> 16);
      acc = acc * mtg_pkg::LCG_MULT + 32'd1;
      mt_words[i] = w;
    end
    read_pos = DEPTH;
    fill_pos = 0;
  endfunction

  // The twist runs in place, so later words see the already updated early ones.
  function automatic void twist_state();
    logic [31:0] y;
    logic [31:0] r;
    for (int k = 0; k < DEPTH; k++) begin
      y = (mt_words[k] & mtg_pkg::MSB_MASK) |
          (mt_words[(k + 1) % DEPTH] & mtg_pkg::LOW31_MASK);
      r = mt_words[(k + mtg_pkg::SHIFT_OFFSET) % DEPTH] ^ (y >> 1);
      if (y[0]) begin
        r = r ^ mtg_pkg::TWIST_XOR;
      end
      mt_words[k] = r;
    end
    read_pos = 0;
  endfunction

  function automatic logic [31:0] temper_word(input logic [31:0] raw);
    logic [31:0] y;
    y = raw;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Applies one request word to the predicted state; returns 1 when it yields a word.
  function automatic logic next_draw(input logic [1:0] op, input logic [31:0] value,
                                     output logic [31:0] word);
    word = '0;
    case (op)
      mtg_pkg::FUNC_DRAW: begin
        if (read_pos >= DEPTH) begin
          if (read_pos == UNSEEDED) begin
            seed_state(mtg_pkg::DEFAULT_SEED);
          end
          twist_state();
        end
        word = temper_word(mt_words[read_pos]);
        read_pos++;
        return 1'b1;
      end
      mtg_pkg::FUNC_SEED: begin
        seed_state(value);
      end
      mtg_pkg::FUNC_LOAD: begin
        if (fill_pos < DEPTH) begin
          mt_words[fill_pos] = value;
          fill_pos++;
          if (fill_pos == DEPTH) begin
            read_pos = DEPTH;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        mt_words[i] = '0;
      end
      read_pos = UNSEEDED;
      fill_pos = 0;
      expected_words.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected word %h with nothing outstanding", $realtime, random_word);
          end
        end else begin
          want = expected_words.pop_front();
          if (random_word !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: random_word mismatch, expected %h, got %h",
                       $realtime, want, random_word);
            end
          end
        end
      end
      if (req_valid && req_ready) begin
        if (next_draw(func, seed_value, want)) begin
          expected_words.insert(expected_words.size(), want);
        end
      end
    end
    fail_count    <= errors;
    words_waiting <= expected_words.size();
  end

endmodule

[tb/sv/mersenne_twister_generator_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for mersenne_twister_generator_top: drives requests and response stalls
// and gives the verdict. Depends on mtg_pkg and mersenne_twister_generator_checker.
module mersenne_twister_generator_top_tb;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int STATE_WORDS    = 624;
  localparam int ITEM_TARGET    = 950;
  localparam int DRAIN_CYCLES   = 2000;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  func = mtg_pkg::FUNC_DRAW;
  logic [31:0] seed_value = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [31:0] random_word;

  int fail_count;
  int words_waiting;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit long_done = 1'b0;

  mersenne_twister_generator_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .func        (func),
    .seed_value  (seed_value),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .random_word (random_word)
  );

  mersenne_twister_generator_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .func          (func),
    .seed_value    (seed_value),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .random_word   (random_word),
    .fail_count    (fail_count),
    .words_waiting (words_waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(99) >= 17);
  end

  // Counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("mersenne_twister_generator_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken. Valid is only
  // lowered when a gap follows, so it is never dropped and raised in one step.
  task automatic send_word(input logic [1:0] op, input logic [31:0] value, input bit counted);
    while (!calm && $urandom_range(99) < 17) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    func       <= op;
    seed_value <= value;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (counted) items_sent++;
  endtask

  task automatic draw_run(input int n);
    repeat (n) send_word(mtg_pkg::FUNC_DRAW, $urandom, 1'b1);
  endtask

  task automatic load_run(input int n);
    repeat (n) send_word(mtg_pkg::FUNC_LOAD, pick_value(), 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Loads before any seed, then draws that trigger the automatic seed over them.
    send_word(mtg_pkg::FUNC_LOAD, 32'hffff_ffff, 1'b1);
    send_word(mtg_pkg::FUNC_LOAD, 32'h0000_0000, 1'b1);
    draw_run(3);
    send_word(FUNC_NONE, 32'hffff_ffff, 1'b0);
    send_word(mtg_pkg::FUNC_SEED, 32'h0000_0000, 1'b1);
    draw_run(1);
    send_word(mtg_pkg::FUNC_SEED, 32'hffff_ffff, 1'b1);
    draw_run(1);
    // A partial load after a draw overwrites words the read position may still reach.
    send_word(mtg_pkg::FUNC_LOAD, 32'ha5a5_a5a5, 1'b1);
    send_word(mtg_pkg::FUNC_LOAD, 32'h5a5a_5a5a, 1'b1);
    draw_run(2);
    send_word(FUNC_NONE, 32'h0000_0000, 1'b0);
    send_word(mtg_pkg::FUNC_SEED, 32'h0000_0001, 1'b1);
    send_word(mtg_pkg::FUNC_SEED, mtg_pkg::DEFAULT_SEED, 1'b1);
    draw_run(1);
    send_word(mtg_pkg::FUNC_LOAD, 32'h8000_0000, 1'b1);
    send_word(mtg_pkg::FUNC_LOAD, 32'h7fff_ffff, 1'b1);
    send_word(mtg_pkg::FUNC_LOAD, 32'h0000_0001, 1'b1);
    draw_run(3);

    // A full load after a seed, a few loads past the end, then draws from the loaded state.
    send_word(mtg_pkg::FUNC_SEED, pick_value(), 1'b1);
    load_run(STATE_WORDS);
    repeat ($urandom_range(1, 6)) send_word(mtg_pkg::FUNC_LOAD, $urandom, 1'b0);
    draw_run($urandom_range(1, 8));

    while (items_sent < ITEM_TARGET) begin
      if (!long_done && items_sent > 700) begin
        // A long unbroken draw stream, one word per cycle with the twist in flight.
        calm = 1'b1;
        draw_run(200);
        calm = 1'b0;
        long_done = 1'b1;
      end else begin
        case ($urandom_range(9))
          0, 1: begin
            send_word(mtg_pkg::FUNC_SEED, pick_value(), 1'b1);
            draw_run($urandom_range(1, 40));
          end
          2, 3, 4: draw_run($urandom_range(1, 40));
          5, 6: begin
            load_run($urandom_range(1, 20));
            draw_run($urandom_range(1, 10));
          end
          7: begin
            repeat ($urandom_range(1, 8)) begin
              logic [1:0] op;
              op = 2'($urandom_range(3));
              send_word(op, pick_value(), op != FUNC_NONE);
            end
          end
          8: begin
            send_word(mtg_pkg::FUNC_SEED, pick_value(), 1'b1);
            load_run($urandom_range(1, 12));
            draw_run($urandom_range(1, 6));
          end
          default: begin
            load_run($urandom_range(1, 6));
            send_word(mtg_pkg::FUNC_SEED, pick_value(), 1'b1);
            draw_run($urandom_range(1, 4));
          end
        endcase
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("mersenne_twister_generator_top verification clean");
    end else begin
      $display("mersenne_twister_generator_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mtg_pkg.sv
rtl/mtg_cell.sv
rtl/mtg_lcg.sv
rtl/mersenne_twister_generator_top.sv
tb/sv/mersenne_twister_generator_checker.sv
tb/sv/mersenne_twister_generator_top_tb.sv
